// ===== src/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// Shared widths, token and error codes, and word types of the source text
// tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Internal widths of the scanner
  localparam int POS_WIDTH   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int VAL_WIDE_W  = VALUE_WIDTH + 4;

  // Widths of the result fields
  localparam int OUT_POS_W = 16;
  localparam int OUT_VAL_W = 32;

  localparam logic [POS_WIDTH-1:0]   POS_MAX = '1;
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = '1;

  // Result queue between scanner and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input item kinds
  localparam logic ITEM_BYTE = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  // Token kinds
  localparam logic [7:0] KIND_EOF    = 8'd0;
  localparam logic [7:0] KIND_INT    = 8'd128;
  localparam logic [7:0] KIND_IDENT  = 8'd129;
  localparam logic [7:0] KIND_EQ     = 8'd130;
  localparam logic [7:0] KIND_NE     = 8'd131;
  localparam logic [7:0] KIND_LE     = 8'd132;
  localparam logic [7:0] KIND_GE     = 8'd133;
  localparam logic [7:0] KIND_SHL    = 8'd134;
  localparam logic [7:0] KIND_SHR    = 8'd135;
  localparam logic [7:0] KIND_LAND   = 8'd136;
  localparam logic [7:0] KIND_LOR    = 8'd137;
  localparam logic [7:0] KIND_ASSIGN = 8'd138;

  // Error codes
  localparam logic [1:0] ERRC_NONE = 2'd0;
  localparam logic [1:0] ERRC_CHAR = 2'd1;
  localparam logic [1:0] ERRC_LONG = 2'd2;

  // One result word
  typedef struct packed {
    logic [7:0]           tok_code;
    logic [OUT_POS_W-1:0] start_offset;
    logic [OUT_POS_W-1:0] token_length;
    logic [OUT_VAL_W-1:0] integer_value;
    logic [1:0]           error_code;
    logic                 last;
  } tok_t;

  // Up to two words produced by one input item
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       w0;
    tok_t       w1;
  } push_t;

endpackage

// ===== src/stt_if.sv =====
// ----------------------------------------------------------------------------
// stt_if
// Valid/ready channels of the tokenizer: text bytes in, token words out.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface stt_out_if;
  import stt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [7:0]           tok_code;
  logic [OUT_POS_W-1:0] start_offset;
  logic [OUT_POS_W-1:0] token_length;
  logic [OUT_VAL_W-1:0] integer_value;
  logic [1:0]           error_code;
  logic                 last;

  modport source (output valid, output tok_code, output start_offset,
                  output token_length, output integer_value, output error_code,
                  output last, input ready);
  modport sink   (input valid, input tok_code, input start_offset,
                  input token_length, input integer_value, input error_code,
                  input last, output ready);
endinterface

// ===== src/stt_scan.sv =====
// ----------------------------------------------------------------------------
// stt_scan
// Front end: classifies each accepted byte, updates the scan state and
// produces zero, one or two token words for the result queue.
// ----------------------------------------------------------------------------
module stt_scan (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          in_kind,
  input  logic [7:0]    in_byte,
  output stt_pkg::push_t push
);
  import stt_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_INT,
    MODE_IDENT,
    MODE_PUNCT,
    MODE_ERR_CHAR,
    MODE_ERR_LONG
  } mode_t;

  // Two-character operator code, KIND_EOF when the pair does not merge
  function automatic logic [7:0] pair_code(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] code;
    code = KIND_EOF;
    if (b == CH_EQ) begin
      unique case (a)
        CH_EQ:    code = KIND_EQ;
        CH_BANG:  code = KIND_NE;
        CH_LT:    code = KIND_LE;
        CH_GT:    code = KIND_GE;
        CH_COLON: code = KIND_ASSIGN;
        default:  code = KIND_EOF;
      endcase
    end else if (a == b) begin
      unique case (a)
        CH_LT:   code = KIND_SHL;
        CH_GT:   code = KIND_SHR;
        CH_AMP:  code = KIND_LAND;
        CH_PIPE: code = KIND_LOR;
        default: code = KIND_EOF;
      endcase
    end
    return code;
  endfunction

  mode_t                  mode_r, mode_nxt;
  logic [POS_WIDTH-1:0]   pos_r, pos_nxt;
  logic [POS_WIDTH-1:0]   start_r, start_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;

  logic                  is_digit, is_alpha, is_space, is_print;
  logic [3:0]            digit_val;
  logic [VAL_WIDE_W-1:0] acc_wide, acc_mac;
  logic                  acc_sat;
  logic [7:0]            pair_kind;
  logic [POS_WIDTH-1:0]  tok_len;
  logic                  flush_ok, has_flush, has_term;
  tok_t                  flush_w, term_w;

  // Byte classes
  assign is_digit  = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign is_alpha  = (in_byte == CH_USCORE) || ((in_byte >= CH_LA) && (in_byte <= CH_LZ)) ||
                     ((in_byte >= CH_A) && (in_byte <= CH_Z));
  assign is_space  = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                     (in_byte == CH_CR) || (in_byte == CH_LF);
  assign is_print  = (in_byte >= CH_SPACE) && (in_byte <= CH_TILDE);
  assign digit_val = 4'(in_byte - CH_0);
  assign pair_kind = pair_code(pend_r, in_byte);

  // acc * 10 + digit with headroom; saturate when it spills past the value width
  assign acc_wide = VAL_WIDE_W'(acc_r);
  assign acc_mac  = (acc_wide << 3) + (acc_wide << 1) + VAL_WIDE_W'(digit_val);
  assign acc_sat  = |acc_mac[VAL_WIDE_W-1:VALUE_WIDTH];

  // Word that closes the open token
  assign flush_ok = (mode_r == MODE_INT) || (mode_r == MODE_IDENT) || (mode_r == MODE_PUNCT);
  assign tok_len  = pos_r - start_r;

  always_comb begin
    flush_w.start_offset  = OUT_POS_W'(start_r);
    flush_w.token_length  = OUT_POS_W'(tok_len);
    flush_w.integer_value = '0;
    flush_w.error_code    = ERRC_NONE;
    flush_w.last          = 1'b0;
    case (mode_r)
      MODE_INT: begin
        flush_w.tok_code      = KIND_INT;
        flush_w.integer_value = OUT_VAL_W'(acc_r);
      end
      MODE_IDENT: flush_w.tok_code = KIND_IDENT;
      default: begin
        flush_w.tok_code     = pend_r;
        flush_w.token_length = OUT_POS_W'(1);
      end
    endcase
  end

  // Next scan state and the terminating word of this item
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;
    has_flush = 1'b0;
    has_term  = 1'b0;

    term_w.tok_code      = KIND_EOF;
    term_w.start_offset  = OUT_POS_W'(pos_r);
    term_w.token_length  = '0;
    term_w.integer_value = '0;
    term_w.error_code    = ERRC_NONE;
    term_w.last          = 1'b1;

    if (in_fire) begin
      if (in_kind == ITEM_END) begin
        // close the text and start over
        has_flush = flush_ok;
        has_term  = 1'b1;
        if (mode_r == MODE_ERR_CHAR) begin
          term_w.error_code = ERRC_CHAR;
        end else if (mode_r == MODE_ERR_LONG) begin
          term_w.error_code = ERRC_LONG;
        end
        mode_nxt  = MODE_IDLE;
        pos_nxt   = '0;
        start_nxt = '0;
        pend_nxt  = '0;
        acc_nxt   = '0;
      end else if ((mode_r == MODE_ERR_CHAR) || (mode_r == MODE_ERR_LONG)) begin
        // stopped: drop bytes
      end else if (pos_r == POS_MAX) begin
        has_flush         = flush_ok;
        has_term          = 1'b1;
        term_w.error_code = ERRC_LONG;
        mode_nxt          = MODE_ERR_LONG;
      end else if ((mode_r == MODE_INT) && is_digit) begin
        acc_nxt = acc_sat ? VAL_MAX : acc_mac[VALUE_WIDTH-1:0];
        pos_nxt = pos_r + POS_WIDTH'(1);
      end else if ((mode_r == MODE_IDENT) && (is_alpha || is_digit)) begin
        pos_nxt = pos_r + POS_WIDTH'(1);
      end else if ((mode_r == MODE_PUNCT) && (pair_kind != KIND_EOF)) begin
        // merged two-character operator
        has_term            = 1'b1;
        term_w.tok_code     = pair_kind;
        term_w.start_offset = OUT_POS_W'(start_r);
        term_w.token_length = OUT_POS_W'(2);
        mode_nxt            = MODE_IDLE;
        pend_nxt            = '0;
        pos_nxt             = pos_r + POS_WIDTH'(1);
      end else begin
        // byte ends the open token and may start a new one
        has_flush = flush_ok;
        mode_nxt  = MODE_IDLE;
        pos_nxt   = pos_r + POS_WIDTH'(1);
        if (is_space) begin
          mode_nxt = MODE_IDLE;
        end else if (is_digit) begin
          mode_nxt  = MODE_INT;
          start_nxt = pos_r;
          acc_nxt   = VALUE_WIDTH'(digit_val);
        end else if (is_alpha) begin
          mode_nxt  = MODE_IDENT;
          start_nxt = pos_r;
        end else if (is_print) begin
          mode_nxt  = MODE_PUNCT;
          start_nxt = pos_r;
          pend_nxt  = in_byte;
        end else begin
          has_term            = 1'b1;
          term_w.token_length = OUT_POS_W'(1);
          term_w.error_code   = ERRC_CHAR;
          mode_nxt            = MODE_ERR_CHAR;
          pos_nxt             = pos_r;
        end
      end
    end
  end

  // Pack words for the queue; the flushed token goes first
  always_comb begin
    push.cnt = 2'(has_flush) + 2'(has_term);
    push.w1  = term_w;
    if (has_flush) begin
      push.w0      = flush_w;
      push.w0.last = ~has_term;
    end else begin
      push.w0 = term_w;
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      pend_r  <= '0;
      acc_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

// ===== src/stt_rqueue.sv =====
// ----------------------------------------------------------------------------
// stt_rqueue
// Short result queue: takes up to two words per cycle from the scanner and
// hands one word per cycle to the output stage when it pops.
// ----------------------------------------------------------------------------
module stt_rqueue (
  input  logic           clk,
  input  logic           rst_n,
  input  stt_pkg::push_t push,
  output logic           push_ok,
  output logic           q_valid,
  output stt_pkg::tok_t  q_word,
  input  logic           q_pop
);
  import stt_pkg::*;

  tok_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r, wp_inc;
  logic [QCNT_W-1:0] cnt_r;

  // Room for the worst case of two words
  assign push_ok = cnt_r <= QCNT_W'(QUEUE_DEPTH - 2);
  assign q_valid = cnt_r != '0;
  assign q_word  = ent_r[rp_r];
  assign wp_inc  = wp_r + QPTR_W'(1);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + QPTR_W'(push.cnt);
      rp_r  <= rp_r + QPTR_W'(q_pop);
      cnt_r <= cnt_r + QCNT_W'(push.cnt) - QCNT_W'(q_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      ent_r[wp_r] <= push.w0;
    end
    if (push.cnt == 2'd2) begin
      ent_r[wp_inc] <= push.w1;
    end
  end

endmodule

// ===== src/stt_emit.sv =====
// ----------------------------------------------------------------------------
// stt_emit
// Back end: output register that presents one token word on the result
// channel and refills from the queue as words are taken.
// ----------------------------------------------------------------------------
module stt_emit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  stt_pkg::tok_t q_word,
  output logic          q_pop,
  stt_out_if.source     out_chan
);
  import stt_pkg::*;

  logic out_valid_r;
  tok_t word_r;

  // Load when empty or when the current word leaves
  assign q_pop = q_valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= q_valid;
    end
    if (q_pop) begin
      word_r <= q_word;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.tok_code      = word_r.tok_code;
  assign out_chan.start_offset  = word_r.start_offset;
  assign out_chan.token_length  = word_r.token_length;
  assign out_chan.integer_value = word_r.integer_value;
  assign out_chan.error_code    = word_r.error_code;
  assign out_chan.last          = word_r.last;

endmodule

// ===== src/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Byte-stream tokenizer: integers, identifiers, punctuation and merged
// two-character operators, with start offset and length on every token.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one word per byte (kind = 0) or an end-of-text word
//   (kind = 1). out_chan carries token words; last marks the final word
//   caused by one input word. A word that ends the text yields the open
//   token, if any, then EOF with the error status of the text.
//   Throughput: one input word per cycle while in_chan.ready is high. A
//   word gives zero, one or two token words; the output drains one per
//   cycle while out_chan.ready is high, so a run of words that each give
//   two tokens slows to the output rate. in_chan.ready is low while the
//   4-entry result queue has fewer than two free entries.
//   Path: a completed token word is written into the result queue, then
//   loaded into the output register that drives out_chan.
//   Stall: when out_chan.ready is low the output register holds, the queue
//   fills, and in_chan.ready drops; nothing is lost.
//   Reset: synchronous, active low; clears the scan state to the start of
//   a new text at offset 0 and empties the queue.
// ----------------------------------------------------------------------------
module source_text_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  stt_in_if.sink    in_chan,
  stt_out_if.source out_chan
);
  import stt_pkg::*;

  logic  in_fire;
  push_t push;
  logic  push_ok;
  logic  q_valid;
  tok_t  q_word;
  logic  q_pop;

  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = push_ok;

  // Front: classify and scan
  stt_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_kind (in_chan.kind),
    .in_byte (in_chan.text_byte),
    .push    (push)
  );

  // Queue between front and back
  stt_rqueue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ok (push_ok),
    .q_valid (q_valid),
    .q_word  (q_word),
    .q_pop   (q_pop)
  );

  // Back: output register
  stt_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  // Words are produced only for a taken input word, and never more than two
  a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (in_fire && (push.cnt != 2'd3)))
    else $error("token words produced without an accepted input word");

  // EOF and error reports always close the words of their input word
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.tok_code == KIND_EOF)) |-> out_chan.last)
    else $error("EOF or error word without last");

  // Merged operators are two bytes long
  a_pair_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.tok_code >= KIND_EQ) &&
     (out_chan.tok_code <= KIND_ASSIGN)) |-> (out_chan.token_length == OUT_POS_W'(2)))
    else $error("two-character operator with wrong length");

  // Integer tokens carry no error and at least one byte
  a_int_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.tok_code == KIND_INT)) |->
    ((out_chan.error_code == ERRC_NONE) && (out_chan.token_length != '0)))
    else $error("malformed integer token");

endmodule
